// ===== rtl/core/smv_pkg.sv =====
// ----------------------------------------------------------------------------
// smv_pkg: shared types and constants
// Command codes, internal operation codes and the queued operation record
// used by the sparse matrix-vector accumulate block.
// ----------------------------------------------------------------------------
`default_nettype none

package smv_pkg;

    localparam int VEC_LEN     = 1024;
    localparam int ADDR_W      = $clog2(VEC_LEN);
    localparam int IDX_W       = 10;
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic REG_ALPHA = 1'b0;
    localparam logic REG_BETA  = 1'b1;

    // input command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_X = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_Y = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ENTRY  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_Y = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // operation codes carried through the queue
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_LOAD_X = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_Y = 3'd1;
    localparam logic [OP_W-1:0] OP_ENTRY  = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_Y = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]          code;
        logic                     row_ok;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] data;
    } op_t;

endpackage

`default_nettype wire

// ===== rtl/core/sparse_matvec_scaled_accumulate.sv =====
// ----------------------------------------------------------------------------
// sparse_matvec_scaled_accumulate: sparse y = alpha*A*x + beta*y
// Commands enter through an intake stage into a four-deep queue; an engine
// with the x and y memories executes them in order, one at a time.
// ----------------------------------------------------------------------------
// Per command: load x and clear finish in the idle state; load y saturates
// beta*value into y[row]; read y waits while the result register is held by
// out_stall; a matrix entry does alpha*value, saturate, times x[column],
// saturate, add into y[row] and saturate. These steps come from the one
// shared 32x32 multiplier and the read-modify-write of the y memory in the
// engine. The four-entry queue accepts while the engine works, so short
// bursts go in at one per cycle until it is full; the sustained rate is the
// engine's. Dropped commands (unused codes, out-of-range loads or entries)
// never reach the queue. saturated reports the sticky flag as of that read.
`default_nettype none

module sparse_matvec_scaled_accumulate (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic                              cfg_index,
    input  wire logic [smv_pkg::DATA_W-1:0]        cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [smv_pkg::CMD_W-1:0]         cmd,
    input  wire logic [smv_pkg::IDX_W-1:0]         row_index,
    input  wire logic [smv_pkg::IDX_W-1:0]         column_index,
    input  wire logic signed [smv_pkg::DATA_W-1:0] data_value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [smv_pkg::IDX_W-1:0]              y_index,
    output logic signed [smv_pkg::DATA_W-1:0]      y_value,
    output logic                                   saturated
);
    import smv_pkg::*;

    localparam logic [DATA_W-1:0] SCALE_ONE = 32'h0001_0000;

    logic signed [DATA_W-1:0] alpha_reg;
    logic signed [DATA_W-1:0] beta_reg;
    logic                     push;
    op_t                      push_op;
    logic                     full;
    logic                     pop;
    op_t                      head;
    logic                     empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= SCALE_ONE;
            beta_reg  <= SCALE_ONE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ALPHA: alpha_reg <= cfg_data;
                REG_BETA:  beta_reg  <= cfg_data;
                default:   alpha_reg <= alpha_reg;
            endcase
        end
    end

    smv_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .row_index    (row_index),
        .column_index (column_index),
        .data_value   (data_value),
        .full         (full),
        .push         (push),
        .push_op      (push_op)
    );

    smv_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (full),
        .pop     (pop),
        .head    (head),
        .empty   (empty)
    );

    smv_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .alpha_scale (alpha_reg),
        .beta_scale  (beta_reg),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .y_index     (y_index),
        .y_value     (y_value),
        .saturated   (saturated)
    );

endmodule

`default_nettype wire

// ===== rtl/core/smv_front.sv =====
// ----------------------------------------------------------------------------
// smv_front: command intake
// Accepts input transfers, decodes the command, drops unused commands and
// out-of-range loads and entries, and pushes the rest into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module smv_front (
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [smv_pkg::CMD_W-1:0]        cmd,
    input  wire logic [smv_pkg::IDX_W-1:0]        row_index,
    input  wire logic [smv_pkg::IDX_W-1:0]        column_index,
    input  wire logic signed [smv_pkg::DATA_W-1:0] data_value,
    input  wire logic                             full,
    output logic                                  push,
    output smv_pkg::op_t                          push_op
);
    import smv_pkg::*;

    logic row_ok;
    logic col_ok;
    logic keep;

    assign row_ok   = int'(row_index) < VEC_LEN;
    assign col_ok   = int'(column_index) < VEC_LEN;
    assign in_stall = full;

    always_comb
    begin
        push_op.code   = OP_CLEAR;
        push_op.row_ok = row_ok;
        push_op.row    = row_index;
        push_op.col    = column_index;
        push_op.data   = data_value;
        keep           = 1'b0;
        case (cmd)
            CMD_LOAD_X:
            begin
                push_op.code = OP_LOAD_X;
                keep         = row_ok;
            end
            CMD_LOAD_Y:
            begin
                push_op.code = OP_LOAD_Y;
                keep         = row_ok;
            end
            CMD_ENTRY:
            begin
                push_op.code = OP_ENTRY;
                keep         = row_ok && col_ok;
            end
            CMD_READ_Y:
            begin
                push_op.code = OP_READ_Y;
                keep         = 1'b1;
            end
            CMD_CLEAR:
            begin
                push_op.code = OP_CLEAR;
                keep         = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // a dropped command is still a completed transfer, just not queued
    assign push = in_valid && !full && keep;

endmodule

`default_nettype wire

// ===== rtl/core/smv_queue.sv =====
// ----------------------------------------------------------------------------
// smv_queue: operation queue
// Short FIFO of decoded operations between the intake and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module smv_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire smv_pkg::op_t  push_op,
    output logic               full,
    input  wire logic          pop,
    output smv_pkg::op_t       head,
    output logic               empty
);
    import smv_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    op_t              slot_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/smv_back.sv =====
// ----------------------------------------------------------------------------
// smv_back: execution engine
// Holds the x and y vectors, runs one queued operation at a time through a
// shared 32x32 multiplier with Q16.16 truncation and saturation, and drives
// the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module smv_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic signed [smv_pkg::DATA_W-1:0] alpha_scale,
    input  wire logic signed [smv_pkg::DATA_W-1:0] beta_scale,
    input  wire smv_pkg::op_t                      head,
    input  wire logic                              empty,
    output logic                                   pop,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [smv_pkg::IDX_W-1:0]              y_index,
    output logic signed [smv_pkg::DATA_W-1:0]      y_value,
    output logic                                   saturated
);
    import smv_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int FRAC_W = 16;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_MUL2 = 3'd2;
    localparam logic [2:0] ST_ADD1 = 3'd3;
    localparam logic [2:0] ST_ADD2 = 3'd4;
    localparam logic [2:0] ST_READ = 3'd5;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] value;
    } sat_res_t;

    // floor(p / 2^16), clamped to the signed 32-bit range
    function automatic sat_res_t qsat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        sat_res_t                 r;
        q       = p >>> FRAC_W;
        r.sat   = 1'b0;
        r.value = q[DATA_W-1:0];
        if (!q[PROD_W-1] && (|q[PROD_W-2:DATA_W-1]))
        begin
            r.sat   = 1'b1;
            r.value = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (q[PROD_W-1] && !(&q[PROD_W-2:DATA_W-1]))
        begin
            r.sat   = 1'b1;
            r.value = {1'b1, {(DATA_W-1){1'b0}}};
        end
        return r;
    endfunction

    logic [DATA_W-1:0] x_mem [VEC_LEN];
    logic [DATA_W-1:0] y_mem [VEC_LEN];

    logic [2:0]               state_reg, state_next;
    op_t                      op_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DATA_W-1:0]        t_reg, t_next;
    logic [DATA_W-1:0]        u_reg, u_next;
    logic [DATA_W-1:0]        x_rd_reg;
    logic [DATA_W-1:0]        y_rd_reg;
    logic                     flag_reg, flag_next;
    logic                     out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]         y_index_reg;
    logic [DATA_W-1:0]        y_value_reg;
    logic                     saturated_reg;
    logic                     out_load;

    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic                     mul_en;
    logic                     rd_en;
    logic                     x_wr_en;
    logic                     y_wr_en;
    logic [DATA_W-1:0]        y_wr_data;
    sat_res_t                 qm;
    logic signed [DATA_W:0]   sum;
    sat_res_t                 sum_sat;

    assign qm  = qsat(prod_reg);
    assign sum = {y_rd_reg[DATA_W-1], y_rd_reg} + {u_reg[DATA_W-1], u_reg};

    always_comb
    begin
        sum_sat.sat   = sum[DATA_W] != sum[DATA_W-1];
        sum_sat.value = sum[DATA_W-1:0];
        if (sum_sat.sat)
        begin
            sum_sat.value = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        t_next         = t_reg;
        u_next         = u_reg;
        pop            = 1'b0;
        mul_en         = 1'b0;
        mul_a          = alpha_scale;
        mul_b          = head.data;
        rd_en          = 1'b0;
        x_wr_en        = 1'b0;
        y_wr_en        = 1'b0;
        y_wr_data      = qm.value;
        out_load       = 1'b0;

        // result register drains independently of the engine
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    case (head.code)
                        OP_LOAD_X:
                        begin
                            x_wr_en = 1'b1;
                        end
                        OP_LOAD_Y:
                        begin
                            mul_a      = beta_scale;
                            mul_en     = 1'b1;
                            state_next = ST_MUL1;
                        end
                        OP_ENTRY:
                        begin
                            mul_en     = 1'b1;
                            rd_en      = 1'b1;
                            state_next = ST_MUL1;
                        end
                        OP_READ_Y:
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_READ;
                        end
                        OP_CLEAR:
                        begin
                            flag_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL1:
            begin
                if (qm.sat)
                begin
                    flag_next = 1'b1;
                end
                if (op_reg.code == OP_LOAD_Y)
                begin
                    y_wr_en    = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    t_next     = qm.value;
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                mul_a      = t_reg;
                mul_b      = x_rd_reg;
                mul_en     = 1'b1;
                state_next = ST_ADD1;
            end
            ST_ADD1:
            begin
                if (qm.sat)
                begin
                    flag_next = 1'b1;
                end
                u_next     = qm.value;
                state_next = ST_ADD2;
            end
            ST_ADD2:
            begin
                if (sum_sat.sat)
                begin
                    flag_next = 1'b1;
                end
                y_wr_en    = 1'b1;
                y_wr_data  = sum_sat.value;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                // hold until the result register is free or drains this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        u_reg <= u_next;
        if (pop)
        begin
            op_reg <= head;
        end
        if (mul_en)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (out_load)
        begin
            y_index_reg   <= op_reg.row;
            y_value_reg   <= op_reg.row_ok ? y_rd_reg : '0;
            saturated_reg <= flag_reg;
        end
    end

    // vector memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (x_wr_en)
        begin
            x_mem[head.row[ADDR_W-1:0]] <= head.data;
        end
        if (rd_en)
        begin
            x_rd_reg <= x_mem[head.col[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (y_wr_en)
        begin
            y_mem[op_reg.row[ADDR_W-1:0]] <= y_wr_data;
        end
        if (rd_en)
        begin
            y_rd_reg <= y_mem[head.row[ADDR_W-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign y_index   = y_index_reg;
    assign y_value   = y_value_reg;
    assign saturated = saturated_reg;

endmodule

`default_nettype wire
